[rtl/core/fcb_pkg.sv]
// fcb_pkg: sizes, request and result types, and scan token types for the bag
// used by fcb_cell, fcb_ctrl and fixed_capacity_bag; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package fcb_pkg;

  // store geometry
  localparam int CAPACITY   = 16;
  localparam int ITEM_WIDTH = 32;
  localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  // fixed port field widths
  localparam int VALUE_W = 32;
  localparam int FIELD_W = 5;

  // request actions
  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_CLEAR  = 2'd3
  } bag_act_e;

  // request payload
  typedef struct packed {
    bag_act_e             action;
    logic [VALUE_W-1:0]   value;
  } bag_req_t;

  // result payload
  typedef struct packed {
    logic                 ok;
    logic [FIELD_W-1:0]   frequency;
    logic [FIELD_W-1:0]   size_now;
    logic                 is_empty;
  } bag_res_t;

  // scan token that walks the cell chain
  typedef struct packed {
    logic                   valid;
    logic [CNT_W-1:0]       left;
    logic                   hit;
    logic [IDX_W-1:0]       first;
    logic [CNT_W-1:0]       freq;
    logic [ITEM_WIDTH-1:0]  last;
  } bag_tok_t;

  // entry write broadcast
  typedef struct packed {
    logic                   en;
    logic [IDX_W-1:0]       idx;
    logic [ITEM_WIDTH-1:0]  data;
  } bag_wr_t;

endpackage

`default_nettype wire

[rtl/core/fcb_cell.sv]
// fcb_cell: one store slot of the bag; holds an entry and passes the scan token on
// depends on fcb_pkg
`timescale 1ns / 1ps
`default_nettype none

module fcb_cell import fcb_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic [IDX_W-1:0]       idx_i,
  input  wire logic [ITEM_WIDTH-1:0]  key_i,
  input  wire bag_wr_t                wr_i,
  input  wire bag_tok_t               tok_i,
  output bag_tok_t                    tok_o
);

  logic [ITEM_WIDTH-1:0] entry_q;
  bag_tok_t              tok_d, tok_q;
  logic                  active;
  logic                  match;

  // update the token when this slot is still inside the held range
  always_comb begin
    active = tok_i.valid && (tok_i.left != '0);
    match  = (entry_q == key_i);
    tok_d  = tok_i;
    if (active) begin
      tok_d.left = tok_i.left - CNT_W'(1);
      if (match) begin
        tok_d.freq = tok_i.freq + CNT_W'(1);
        if (!tok_i.hit) begin
          tok_d.hit   = 1'b1;
          tok_d.first = idx_i;
        end
      end
      // last held entry, picked up for a remove
      if (tok_i.left == CNT_W'(1)) begin
        tok_d.last = entry_q;
      end
    end
  end

  // token hand-off to the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  // entry storage, no reset
  always_ff @(posedge clk_i) begin
    if (wr_i.en && (wr_i.idx == idx_i)) begin
      entry_q <= wr_i.data;
    end
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire

[rtl/core/fcb_ctrl.sv]
// fcb_ctrl: request sequencer, entry count and result register of the bag
// depends on fcb_pkg; drives the fcb_cell chain
`timescale 1ns / 1ps
`default_nettype none

module fcb_ctrl import fcb_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start,
  input  wire bag_req_t               req_i,
  output logic                        busy,
  output logic                        done_o,
  output bag_res_t                    res_o,
  output bag_tok_t                    launch_o,
  output logic [ITEM_WIDTH-1:0]       key_o,
  output bag_wr_t                     wr_o,
  input  wire bag_tok_t               tok_i
);

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_e;

  state_e                 state_q;
  logic [CNT_W-1:0]       count_q;
  bag_act_e               act_q;
  logic [ITEM_WIDTH-1:0]  key_q;
  logic                   done_q;
  bag_res_t               res_q;
  bag_tok_t               launch_q;
  bag_wr_t                wr_q;

  // pack one result word
  function automatic bag_res_t mk_res(logic ok, logic [CNT_W-1:0] freq,
                                      logic [CNT_W-1:0] size);
    bag_res_t r;
    r.ok        = ok;
    r.frequency = FIELD_W'(freq);
    r.size_now  = FIELD_W'(size);
    r.is_empty  = (size == '0);
    return r;
  endfunction

  // sequencer with registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      act_q    <= ACT_ADD;
      key_q    <= '0;
      done_q   <= 1'b0;
      res_q    <= '0;
      launch_q <= '0;
      wr_q     <= '0;
    end else begin
      done_q         <= 1'b0;
      launch_q.valid <= 1'b0;
      wr_q.en        <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start) begin
            act_q <= req_i.action;
            key_q <= ITEM_WIDTH'(req_i.value);
            case (req_i.action)
              ACT_ADD: begin
                done_q <= 1'b1;
                if (count_q < CNT_W'(CAPACITY)) begin
                  wr_q.en   <= 1'b1;
                  wr_q.idx  <= IDX_W'(count_q);
                  wr_q.data <= ITEM_WIDTH'(req_i.value);
                  count_q   <= count_q + CNT_W'(1);
                  res_q     <= mk_res(1'b1, '0, count_q + CNT_W'(1));
                end else begin
                  res_q     <= mk_res(1'b0, '0, count_q);
                end
              end
              ACT_CLEAR: begin
                done_q  <= 1'b1;
                count_q <= '0;
                res_q   <= mk_res(1'b0, '0, '0);
              end
              default: begin
                // remove and query walk the chain
                launch_q.valid <= 1'b1;
                launch_q.left  <= count_q;
                launch_q.hit   <= 1'b0;
                launch_q.first <= '0;
                launch_q.freq  <= '0;
                launch_q.last  <= '0;
                state_q        <= S_SCAN;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (tok_i.valid) begin
            done_q  <= 1'b1;
            state_q <= S_IDLE;
            if (act_q == ACT_REMOVE) begin
              if (tok_i.hit) begin
                // move the last entry into the freed slot
                wr_q.en   <= 1'b1;
                wr_q.idx  <= tok_i.first;
                wr_q.data <= tok_i.last;
                count_q   <= count_q - CNT_W'(1);
                res_q     <= mk_res(1'b1, '0, count_q - CNT_W'(1));
              end else begin
                res_q     <= mk_res(1'b0, '0, count_q);
              end
            end else begin
              res_q <= mk_res(tok_i.freq != '0, tok_i.freq, count_q);
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy     = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign res_o    = res_q;
  assign launch_o = launch_q;
  assign key_o    = key_q;
  assign wr_o     = wr_q;

endmodule

`default_nettype wire

[rtl/core/fixed_capacity_bag.sv]
// Multiset bag of up to CAPACITY entries: sequencer plus a chain of entry cells.
// Add and clear: result strobe in the cycle after the request is taken, and the next
// request can be taken in that same cycle, so one request per cycle.
// Remove and query: the scan token walks all CAPACITY cells, one per cycle, from the
// launch register through each cell register, and the result strobe follows from the
// result register; the next request is taken only once the sequencer is back in idle.
// busy is high while a scan is running. The receiver cannot stall.
// Reset (rst_ni low, asynchronous) empties the bag.
// depends on fcb_pkg, fcb_cell, fcb_ctrl
`timescale 1ns / 1ps
`default_nettype none

module fixed_capacity_bag import fcb_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start,
  input  wire bag_req_t  req_i,
  output logic           busy,
  output logic           done_o,
  output bag_res_t       res_o
);

  bag_tok_t              tok [CAPACITY+1];
  logic [ITEM_WIDTH-1:0] key;
  bag_wr_t               wr;

  // sequencer
  fcb_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .req_i    (req_i),
    .busy     (busy),
    .done_o   (done_o),
    .res_o    (res_o),
    .launch_o (tok[0]),
    .key_o    (key),
    .wr_o     (wr),
    .tok_i    (tok[CAPACITY])
  );

  // chain of entry cells
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    fcb_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (IDX_W'(k)),
      .key_i  (key),
      .wr_i   (wr),
      .tok_i  (tok[k]),
      .tok_o  (tok[k+1])
    );
  end

endmodule

`default_nettype wire
